// ===== sv/free_list_mark_sweep_pool_macros.svh =====
// Assertion macros shared by the pool's RTL modules.
`ifndef FREE_LIST_MARK_SWEEP_POOL_MACROS_SVH
`define FREE_LIST_MARK_SWEEP_POOL_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FLSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FLSP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== sv/flsp_pkg.sv =====
// Package with the pool's sizes, codes and interface structs.
`timescale 1ns / 1ps

package flsp_pkg;

   localparam int NUM_CELLS = 256;
   localparam int IDX_W     = 8;
   localparam int CNT_W     = 9;
   localparam int OP_W      = 3;
   localparam int ST_W      = 2;
   localparam int RAM_AW    = $clog2(NUM_CELLS);

   localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
   localparam logic [OP_W-1:0] OP_MARK  = 3'd1;
   localparam logic [OP_W-1:0] OP_FORCE = 3'd2;
   localparam logic [OP_W-1:0] OP_SWEEP = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] cell_index;
   } req_payload_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [IDX_W-1:0] granted_cell;
      logic [CNT_W-1:0] cells_in_use;
      logic [CNT_W-1:0] cells_collected;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic init_step;
      logic load;
      logic exec;
      logic sweep_step;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ptr_last;
      logic is_sweep;
   } dp_stat_type;

endpackage

// ===== sv/flsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module flsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/flsp_ctrl.sv =====
// Controller state machine that sequences link init, requests and sweeps.
`timescale 1ns / 1ps
`include "free_list_mark_sweep_pool_macros.svh"

module flsp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  flsp_pkg::dp_stat_type stat,
   output flsp_pkg::ctl_cmd_type cmd
);
   import flsp_pkg::*;

   localparam logic [1:0] S_INIT  = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_SWEEP = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.ptr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.is_sweep ? S_SWEEP : S_IDLE;
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.ptr_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `FLSP_ASSERT_NXT(a_accept_to_exec, clock, reset, start && !busy, state_ff == S_EXEC)
   `FLSP_ASSERT_NXT(a_exec_leaves, clock, reset, state_ff == S_EXEC, state_ff == S_IDLE || state_ff == S_SWEEP)
   `FLSP_ASSERT_NXT(a_init_holds, clock, reset, state_ff == S_INIT && !stat.ptr_last, state_ff == S_INIT)

endmodule

// ===== sv/flsp_dp.sv =====
// Datapath holding the free list, per-cell flags, counters and result register.
`timescale 1ns / 1ps
`include "free_list_mark_sweep_pool_macros.svh"

module flsp_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  flsp_pkg::ctl_cmd_type    cmd,
   output flsp_pkg::dp_stat_type    stat,
   input  flsp_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   output flsp_pkg::rsp_payload_type rsp_data
);
   import flsp_pkg::*;

   req_payload_type req_ff, req_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic                 empty_ff, empty_in;
   logic [CNT_W-1:0]     in_use_ff, in_use_in;
   logic [CNT_W-1:0]     collected_ff, collected_in;

   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr;
   logic [IDX_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]  ram_rdata;

   logic              free_we;
   logic              marked_we;
   logic              forced_we;
   logic [RAM_AW-1:0] flag_waddr;
   logic              free_wdata;
   logic              marked_wdata;
   logic              forced_wdata;
   logic [RAM_AW-1:0] flag_raddr;
   logic              free_rdata;
   logic              marked_rdata;
   logic              forced_rdata;

   logic              in_range;
   logic [RAM_AW-1:0] req_cell;
   logic [RAM_AW-1:0] pcell;
   logic [RAM_AW-1:0] hcell;
   logic              ptr_last;
   logic              sweep_hit;
   logic [CNT_W-1:0]  in_use_inc;
   logic              alloc_ok;

   // The link of the current head is read every cycle, so it is ready
   // in the cycle after a request is taken.
   flsp_ram #(
      .WIDTH(IDX_W),
      .DEPTH(NUM_CELLS)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(hcell),
      .rd_data(ram_rdata)
   );

   // The flag memories share one read address: the requested cell while a
   // request is taken, otherwise the cell the sweep visits next, so each
   // sweep step finds the flags of its cell already read out.
   flsp_ram #(
      .WIDTH(1),
      .DEPTH(NUM_CELLS)
   ) u_free_ram (
      .clock  (clock),
      .wr_en  (free_we),
      .wr_addr(flag_waddr),
      .wr_data(free_wdata),
      .rd_addr(flag_raddr),
      .rd_data(free_rdata)
   );

   flsp_ram #(
      .WIDTH(1),
      .DEPTH(NUM_CELLS)
   ) u_marked_ram (
      .clock  (clock),
      .wr_en  (marked_we),
      .wr_addr(flag_waddr),
      .wr_data(marked_wdata),
      .rd_addr(flag_raddr),
      .rd_data(marked_rdata)
   );

   flsp_ram #(
      .WIDTH(1),
      .DEPTH(NUM_CELLS)
   ) u_forced_ram (
      .clock  (clock),
      .wr_en  (forced_we),
      .wr_addr(flag_waddr),
      .wr_data(forced_wdata),
      .rd_addr(flag_raddr),
      .rd_data(forced_rdata)
   );

   assign in_range   = (CNT_W'(req_ff.cell_index) < CNT_W'(NUM_CELLS));
   assign req_cell   = req_ff.cell_index[RAM_AW-1:0];
   assign pcell      = ptr_ff[RAM_AW-1:0];
   assign hcell      = head_ff[RAM_AW-1:0];
   assign ptr_last   = (ptr_ff == IDX_W'(NUM_CELLS - 1));
   assign sweep_hit  = !free_rdata && (!marked_rdata || forced_rdata);
   assign in_use_inc = in_use_ff + 1'b1;
   assign alloc_ok   = cmd.exec && (req_ff.op == OP_ALLOC) && !empty_ff;
   assign flag_raddr = cmd.load ? req_data.cell_index[RAM_AW-1:0] : ptr_in[RAM_AW-1:0];

   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      ptr_in       = ptr_ff;
      head_in      = head_ff;
      empty_in     = empty_ff;
      in_use_in    = in_use_ff;
      collected_in = collected_ff;
      ram_we       = 1'b0;
      ram_waddr    = pcell;
      ram_wdata    = '0;
      free_we      = 1'b0;
      marked_we    = 1'b0;
      forced_we    = 1'b0;
      flag_waddr   = pcell;
      free_wdata   = 1'b1;
      marked_wdata = 1'b0;
      forced_wdata = 1'b0;

      // The init pass chains the links in order and marks every cell free.
      if (cmd.init_step) begin
         ram_we    = 1'b1;
         ram_wdata = ptr_last ? '0 : ptr_ff + 1'b1;
         ptr_in    = ptr_last ? '0 : ptr_ff + 1'b1;
         free_we   = 1'b1;
         marked_we = 1'b1;
         forced_we = 1'b1;
      end

      if (cmd.load) begin
         req_in = req_data;
      end

      if (cmd.exec) begin
         rsp_valid_in           = 1'b1;
         rsp_in.status          = ST_OK;
         rsp_in.granted_cell    = '0;
         rsp_in.cells_in_use    = in_use_ff;
         rsp_in.cells_collected = '0;
         unique case (req_ff.op)
            OP_ALLOC: begin
               if (empty_ff) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rsp_in.granted_cell = head_ff;
                  rsp_in.cells_in_use = in_use_inc;
                  head_in             = ram_rdata;
                  free_we             = 1'b1;
                  flag_waddr          = hcell;
                  free_wdata          = 1'b0;
                  in_use_in           = in_use_inc;
                  empty_in            = (in_use_inc >= CNT_W'(NUM_CELLS));
               end
            end
            OP_MARK: begin
               if (in_range) begin
                  marked_we    = 1'b1;
                  flag_waddr   = req_cell;
                  marked_wdata = 1'b1;
               end else begin
                  rsp_in.status = ST_BAD;
               end
            end
            OP_FORCE: begin
               if (in_range) begin
                  forced_we    = 1'b1;
                  flag_waddr   = req_cell;
                  forced_wdata = 1'b1;
               end else begin
                  rsp_in.status = ST_BAD;
               end
            end
            OP_SWEEP: begin
               rsp_valid_in = 1'b0;
               ptr_in       = '0;
               collected_in = '0;
            end
            OP_QUERY: begin
               rsp_in.status = (in_range && !free_rdata) ? ST_OK : ST_BAD;
            end
            default: begin
               rsp_in.status = ST_BAD;
            end
         endcase
      end

      // Each sweep step clears the visited cell's mark and force flags and
      // frees it when it is reclaimed.
      if (cmd.sweep_step) begin
         marked_we = 1'b1;
         forced_we = 1'b1;
         if (sweep_hit) begin
            ram_we       = 1'b1;
            ram_waddr    = pcell;
            ram_wdata    = empty_ff ? '0 : head_ff;
            head_in      = ptr_ff;
            empty_in     = 1'b0;
            free_we      = 1'b1;
            in_use_in    = (in_use_ff != '0) ? in_use_ff - 1'b1 : in_use_ff;
            collected_in = collected_ff + 1'b1;
         end
         ptr_in = ptr_last ? '0 : ptr_ff + 1'b1;
         if (ptr_last) begin
            rsp_valid_in           = 1'b1;
            rsp_in.status          = ST_OK;
            rsp_in.granted_cell    = '0;
            rsp_in.cells_in_use    = in_use_in;
            rsp_in.cells_collected = collected_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         head_ff      <= '0;
         empty_ff     <= 1'b0;
         in_use_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         head_ff      <= head_in;
         empty_ff     <= empty_in;
         in_use_ff    <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      collected_ff <= collected_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign stat.ptr_last = ptr_last;
   assign stat.is_sweep = (req_ff.op == OP_SWEEP);

   `FLSP_ASSERT_IMP(a_empty_full, clock, reset, 1'b1, empty_ff == (in_use_ff == CNT_W'(NUM_CELLS)))
   `FLSP_ASSERT_IMP(a_count_range, clock, reset, 1'b1, in_use_ff <= CNT_W'(NUM_CELLS))
   `FLSP_ASSERT_NXT(a_alloc_count, clock, reset, alloc_ok, in_use_ff == $past(in_use_ff) + 1'b1)

endmodule

// ===== sv/free_list_mark_sweep_pool.sv =====
// Top level of the mark-and-sweep free-list cell pool.
// Alloc, mark, force free, query: the request is registered and executed; its result is registered.
// A new request is not taken until the previous one has left the EXEC state.
// Sweep visits one cell a cycle and strobes its result after the last cell.
// After reset, busy stays high while the link and flag memories are filled.
`timescale 1ns / 1ps

module free_list_mark_sweep_pool (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  flsp_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   output flsp_pkg::rsp_payload_type rsp_data
);
   import flsp_pkg::*;

   // The controller only steps the datapath through the init pass, the load and
   // one-cycle execute step of a request, and the cell-by-cell sweep.
   ctl_cmd_type cmd;
   dp_stat_type stat;

   // A request is taken whenever start is high while busy is low. The
   // result register lets the next request be taken in the same cycle
   // that the previous result is shown, so results never block input.
   flsp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   // The datapath owns the free list: its head, the link memory and the
   // per-cell free, mark and force flag memories. A sweep pushes each
   // reclaimed cell onto the head of the list, in ascending cell order,
   // and clears the mark and force flags of every cell as it visits it.
   flsp_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the mark-and-sweep free-list cell pool.
`timescale 1ns / 1ps

module tb_top;
   import flsp_pkg::*;

   // Op codes the block does not define; they must come back as a bad status.
   localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

   // The longest stretch with no request or result taken is the link memory
   // chaining after reset or one sweep's walk over the cells, plus the
   // longest random gap. The limit is several times that.
   localparam int WATCHDOG_LIMIT = 12 * NUM_CELLS;
   localparam int DRAIN_CYCLES   = 16;
   localparam int RANDOM_BLOCKS  = 39;
   localparam int BLOCK_REQUESTS = 40;
   localparam int GRANT_HISTORY  = 64;

   logic            clock;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   rsp_payload_type rsp_data;

   free_list_mark_sweep_pool DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Shadow copy of the pool. It is updated the moment a request is taken,
   // so its state always matches the order in which the block sees requests.
   logic [IDX_W-1:0] free_link [NUM_CELLS];
   logic [IDX_W-1:0] pool_head;
   logic             pool_exhausted;
   logic             is_free   [NUM_CELLS];
   logic             is_marked [NUM_CELLS];
   logic             is_forced [NUM_CELLS];
   int               cells_used;

   rsp_payload_type  pending_rsp [$];
   logic [IDX_W-1:0] recent_grants [$];
   int               mismatch_count = 0;
   int               stall_cycles = 0;
   bit               idle_on = 1'b1;

   initial begin
      for (int i = 0; i < NUM_CELLS; i++) begin
         free_link[i] = (i + 1 < NUM_CELLS) ? IDX_W'(i + 1) : '0;
         is_free[i]   = 1'b1;
         is_marked[i] = 1'b0;
         is_forced[i] = 1'b0;
      end
      pool_head      = '0;
      pool_exhausted = 1'b0;
      cells_used     = 0;
   end

   // Works out the response to one request and advances the shadow pool.
   function automatic rsp_payload_type predict_pool(req_payload_type rq);
      rsp_payload_type r;
      int              target_cell;
      int              freed;
      r     = '0;
      freed = 0;
      target_cell = rq.cell_index;
      r.status = ST_OK;
      case (rq.op)
         OP_ALLOC: begin
            if (pool_exhausted) begin
               r.status = ST_EMPTY;
            end else begin
               r.granted_cell = pool_head;
               is_free[pool_head] = 1'b0;
               recent_grants.push_back(pool_head);
               if (recent_grants.size() > GRANT_HISTORY) void'(recent_grants.pop_front());
               pool_head = free_link[pool_head];
               cells_used++;
               // No sentinel link: the list runs dry exactly when every cell is in use.
               if (cells_used >= NUM_CELLS) pool_exhausted = 1'b1;
            end
         end
         OP_MARK: begin
            if (target_cell < NUM_CELLS) is_marked[target_cell] = 1'b1;
            else r.status = ST_BAD;
         end
         OP_FORCE: begin
            if (target_cell < NUM_CELLS) is_forced[target_cell] = 1'b1;
            else r.status = ST_BAD;
         end
         OP_SWEEP: begin
            // Ascending walk; a cell already on the list is never pushed again.
            for (int i = 0; i < NUM_CELLS; i++) begin
               if (!is_free[i] && (!is_marked[i] || is_forced[i])) begin
                  free_link[i]   = pool_exhausted ? '0 : pool_head;
                  pool_head      = IDX_W'(i);
                  pool_exhausted = 1'b0;
                  is_free[i]     = 1'b1;
                  if (cells_used > 0) cells_used--;
                  freed++;
               end
               is_marked[i] = 1'b0;
               is_forced[i] = 1'b0;
            end
         end
         OP_QUERY: begin
            r.status = (target_cell < NUM_CELLS && !is_free[target_cell]) ? ST_OK : ST_BAD;
         end
         default: begin
            r.status = ST_BAD;
         end
      endcase
      r.cells_in_use    = CNT_W'(cells_used);
      r.cells_collected = CNT_W'(freed);
      return r;
   endfunction

   // Mostly short gaps, now and then a long one; none while idling is off.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Presents one request and holds it until the block takes it. When no gap
   // follows, start is left high so the next call can present its request in
   // the same time step without a low pulse in between.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
      req_payload_type rq;
      int              gap;
      rq.op         = op;
      rq.cell_index = idx;
      req_data <= rq;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_rsp.push_back(predict_pool(rq));
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Picks a target cell, usually one that was handed out recently so that
   // marks and force frees land on allocated cells.
   function automatic logic [IDX_W-1:0] pick_cell();
      if (recent_grants.size() > 0 && $urandom_range(0, 99) < 70)
         return recent_grants[$urandom_range(0, recent_grants.size() - 1)];
      return IDX_W'($urandom_range(0, NUM_CELLS - 1));
   endfunction

   // Compares every strobed response with the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_data);
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.granted_cell !== want.granted_cell) begin
               $error("granted_cell: expected %0d, got %0d",
                      want.granted_cell, rsp_data.granted_cell);
               mismatch_count++;
            end
            if (rsp_data.cells_in_use !== want.cells_in_use) begin
               $error("cells_in_use: expected %0d, got %0d",
                      want.cells_in_use, rsp_data.cells_in_use);
               mismatch_count++;
            end
            if (rsp_data.cells_collected !== want.cells_collected) begin
               $error("cells_collected: expected %0d, got %0d",
                      want.cells_collected, rsp_data.cells_collected);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run if neither side moves anything for too long.
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Hand-picked sequence: free and allocated queries, flags on free cells,
   // a cell both marked and forced, the unused op codes and index extremes.
   task automatic test_directed();
      send_request(OP_QUERY, 8'd0);
      send_request(OP_QUERY, 8'd255);
      send_request(OP_ALLOC, 8'd255);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd170);
      send_request(OP_ALLOC, 8'd85);
      send_request(OP_QUERY, 8'd0);
      send_request(OP_MARK, 8'd0);
      send_request(OP_MARK, 8'd3);
      send_request(OP_FORCE, 8'd3);
      send_request(OP_MARK, 8'd200);
      send_request(OP_FORCE, 8'd1);
      send_request(OP_FORCE, 8'd255);
      send_request(OP_UNUSED_LO, 8'd0);
      send_request(OP_UNUSED_MID, 8'd255);
      send_request(OP_UNUSED_HI, 8'd127);
      send_request(OP_SWEEP, 8'd0);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_QUERY, 8'd1);
      send_request(OP_SWEEP, 8'd255);
      send_request(OP_QUERY, 8'd0);
   endtask

   // Drains the whole pool, asks for more than it holds, then sweeps with
   // eight random cells marked and three picked cells forced out anyway.
   task automatic test_exhaustion();
      idle_on = ($urandom_range(0, 1) == 1);
      while (!pool_exhausted) begin
         if ($urandom_range(0, 9) == 0) send_request(OP_QUERY, pick_cell());
         else send_request(OP_ALLOC, IDX_W'($urandom()));
      end
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_ALLOC, 8'd255);
      send_request(OP_QUERY, 8'd255);
      for (int i = 0; i < 8; i++) begin
         send_request(OP_MARK, IDX_W'($urandom()));
         if (i % 3 == 0) send_request(OP_FORCE, pick_cell());
      end
      send_request(OP_SWEEP, IDX_W'($urandom()));
      send_request(OP_SWEEP, IDX_W'($urandom()));
      idle_on = 1'b1;
   endtask

   // Blocks of random requests. Each block has its own allocation bias so the
   // pool swings between nearly empty and full, and some blocks run gap-free.
   task automatic test_random_traffic();
      int alloc_bias;
      int roll;
      int pick;
      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         alloc_bias = $urandom_range(10, 70);
         idle_on    = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < BLOCK_REQUESTS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               send_request(OP_SWEEP, IDX_W'($urandom()));
            end else if (roll < 5) begin
               send_request(OP_UNUSED_LO + OP_W'($urandom_range(0, 2)), IDX_W'($urandom()));
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < alloc_bias) send_request(OP_ALLOC, IDX_W'($urandom()));
               else if (pick < alloc_bias + (100 - alloc_bias) * 2 / 5)
                  send_request(OP_MARK, pick_cell());
               else if (pick < alloc_bias + (100 - alloc_bias) * 3 / 4)
                  send_request(OP_QUERY, pick_cell());
               else send_request(OP_FORCE, pick_cell());
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_exhaustion();
      test_random_traffic();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
